>>> rtl/hdmc_pkg.sv
// Shared types and constants for the hard-disk Monte Carlo move block.
package hdmc_pkg;

  localparam int CfgIdxBits = 3;
  localparam int StepBits   = 16;
  localparam int RadBits    = 15;
  localparam int SpecBits   = 2;

  localparam logic [CfgIdxBits-1:0] REG_STEP  = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_RAD0  = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_RAD1  = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_RAD2  = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_RAD3  = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

>>> rtl/hard_disk_mc_move.sv
// Top level of the hard-disk Monte Carlo move block.
// One item is taken at a time: start is accepted while busy is low. A load passes
// through the read state, writing the stores if the index is in range, then done. A
// move of a valid disk reads the disk, then streams every store entry through the
// registered store read and a two-cell test chain, one entry per cycle, as each
// coordinate store has a single port, followed by a drain of the chain. A move of
// an entry never loaded passes through the prep state to done and returns all
// zeros. Results appear for one cycle on done with accepted, pos_x and pos_y; the
// receiver cannot stall them. After reset a clearing pass over every entry resets
// the valid store; start is not taken meanwhile (busy high).
module hard_disk_mc_move #(
  parameter int MAX_DISKS   = 1024,
  parameter int MAX_SPECIES = 4,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [9:0]  particle_index,
  input  logic [15:0] value_x,
  input  logic [15:0] value_y,
  input  logic [1:0]  species,
  output logic        done,
  output logic        accepted,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [hdmc_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import hdmc_pkg::*;

  localparam int AW = $clog2(MAX_DISKS);
  localparam int CB = COORD_BITS;
  localparam logic [CB-1:0] HALF = CB'(1) << (CB - 1);

  logic [StepBits-1:0] step_scale;
  logic [RadBits-1:0]  rad [4];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale <= 16'd6554;
      for (int i = 0; i < 4; i++) rad[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP: step_scale <= cfg_data;
        REG_RAD0: rad[0] <= cfg_data[RadBits-1:0];
        REG_RAD1: rad[1] <= cfg_data[RadBits-1:0];
        REG_RAD2: rad[2] <= cfg_data[RadBits-1:0];
        REG_RAD3: rad[3] <= cfg_data[RadBits-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [RadBits-1:0] rad_of(input logic [1:0] sp,
                                                  input logic [RadBits-1:0] r0,
                                                  input logic [RadBits-1:0] r1,
                                                  input logic [RadBits-1:0] r2,
                                                  input logic [RadBits-1:0] r3);
    logic [RadBits-1:0] r;
    case (sp)
      2'd0: r = r0;
      2'd1: r = r1;
      2'd2: r = r2;
      default: r = r3;
    endcase
    if (32'(sp) >= MAX_SPECIES) r = '0;
    return r;
  endfunction

  state_t state, state_next;
  logic [AW:0]   cnt;
  logic [AW-1:0] idx;
  logic          cmd;
  logic [CB-1:0] wx, wy;
  logic [1:0]    sp_in;
  logic          hit;
  logic          idx_ok;
  logic [CB-1:0] nx, ny, ox, oy;
  logic [RadBits-1:0] rme;
  logic          rvld_m;

  // stores
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [CB-1:0] rx, ry;
  logic [1:0]    rsp;
  logic          rvld;
  logic          vld_wd;

  hdmc_ram #(.WIDTH(CB), .DEPTH(MAX_DISKS)) u_x (
    .clk, .we(ram_we && state != ST_IDLE), .addr(ram_addr), .wdata(wx), .rdata(rx));
  hdmc_ram #(.WIDTH(CB), .DEPTH(MAX_DISKS)) u_y (
    .clk, .we(ram_we && state != ST_IDLE), .addr(ram_addr), .wdata(wy), .rdata(ry));
  hdmc_ram #(.WIDTH(2), .DEPTH(MAX_DISKS)) u_s (
    .clk, .we(ram_we && cmd == CMD_LOAD && state != ST_IDLE), .addr(ram_addr),
    .wdata(sp_in), .rdata(rsp));
  hdmc_ram #(.WIDTH(1), .DEPTH(MAX_DISKS)) u_v (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(vld_wd), .rdata(rvld));

  // clear pass
  logic          clr_act;
  logic [AW:0]   clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_act <= 1'b1;
      clr_cnt <= '0;
    end else if (clr_act) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (AW+1)'(MAX_DISKS - 1)) clr_act <= 1'b0;
    end
  end

  // displacement: floor(step*(w-half)/2^16)
  function automatic logic [CB-1:0] disp(input logic [CB-1:0] w,
                                         input logic [StepBits-1:0] s);
    logic signed [CB:0]            c;
    logic signed [CB+StepBits+1:0] p;
    c = $signed({1'b0, w}) - $signed({1'b0, HALF});
    p = $signed({1'b0, s}) * c;
    return p[CB+15:16];
  endfunction

  // scan stream
  logic          s_vld, s_vld_q;
  logic [AW-1:0] s_addr, s_addr_q;
  logic          feed_v;
  logic [2*CB+1:0] c0_in;
  logic          v1, v2;
  logic [CB-1:0] a1, b1;
  logic [2*CB+1:0] c1, c2;
  logic [RadBits:0] rs;
  logic [2*RadBits+1:0] rs2;
  logic [2*RadBits+1:0] rs2_p1;

  assign s_vld  = (state == ST_SCAN) && (cnt < (AW+1)'(MAX_DISKS));
  assign s_addr = cnt[AW-1:0];
  assign feed_v = s_vld_q && rvld && (s_addr_q != idx);
  assign rs  = {1'b0, rme} + {1'b0, rad_of(rsp, rad[0], rad[1], rad[2], rad[3])};
  assign c0_in = '0;

  hdmc_cell #(.CB(CB), .KIND(0)) u_c0 (
    .clk, .rst, .in_vld(feed_v), .in_a(rx), .in_b(ry), .in_c(c0_in),
    .cand_x(nx), .cand_y(ny), .out_vld(v1), .out_a(a1), .out_b(b1), .out_c(c1));
  hdmc_cell #(.CB(CB), .KIND(1)) u_c1 (
    .clk, .rst, .in_vld(v1), .in_a(a1), .in_b(b1), .in_c(c1),
    .cand_x(nx), .cand_y(ny), .out_vld(v2), .out_a(), .out_b(), .out_c(c2));

  // radius square pipelined alongside (2 stages to meet c2)
  always_ff @(posedge clk) begin
    rs2 <= rs * rs;
    rs2_p1 <= rs2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= s_vld;
    end
    s_addr_q <= s_addr;
  end

  // FSM
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start && !busy) state_next = ST_READ;
      ST_READ:  state_next = (!idx_ok || cmd == CMD_LOAD) ? ST_DONE : ST_PREP;
      ST_PREP:  state_next = rvld ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (cnt == (AW+1)'(MAX_DISKS)) state_next = ST_DRAIN;
      ST_DRAIN: if (cnt == (AW+1)'(5)) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx;
    vld_wd = 1'b1;
    if (clr_act) begin
      ram_we = 1'b1;
      ram_addr = clr_cnt[AW-1:0];
      vld_wd = 1'b0;
    end else begin
      case (state)
        ST_READ: ram_we = idx_ok && cmd == CMD_LOAD;
        ST_SCAN: ram_addr = s_addr;
        ST_DONE: ram_we = idx_ok && cmd == CMD_MOVE && accepted;
        default: ;
      endcase
    end
  end

  logic hit_now;
  assign hit_now = v2 && (64'(c2) <= 64'(rs2_p1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      ST_IDLE: begin
        cmd <= command;
        idx <= AW'(particle_index);
        idx_ok <= 32'(particle_index) < MAX_DISKS;
        wx <= CB'(value_x);
        wy <= CB'(value_y);
        sp_in <= species;
        hit <= 1'b0;
        cnt <= '0;
      end
      ST_PREP: begin
        ox <= rx;
        oy <= ry;
        nx <= rx + disp(wx, step_scale);
        ny <= ry + disp(wy, step_scale);
        rme <= rad_of(rsp, rad[0], rad[1], rad[2], rad[3]);
      end
      ST_SCAN: begin
        cnt <= (cnt == (AW+1)'(MAX_DISKS)) ? '0 : cnt + 1'b1;
        if (hit_now) hit <= 1'b1;
      end
      ST_DRAIN: begin
        cnt <= cnt + 1'b1;
        if (hit_now) hit <= 1'b1;
        if (state_next == ST_DONE) begin
          wx <= nx;
          wy <= ny;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    done = state == ST_DONE;
    accepted = 1'b0;
    pos_x = '0;
    pos_y = '0;
    if (done && idx_ok) begin
      if (cmd == CMD_LOAD) begin
        accepted = 1'b1;
        pos_x = 16'(wx);
        pos_y = 16'(wy);
      end else if (rvld_m) begin
        accepted = !hit;
        pos_x = 16'(hit ? ox : nx);
        pos_y = 16'(hit ? oy : ny);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) rvld_m <= rvld;
  end

  always_comb begin
    busy = (state != ST_IDLE) || clr_act;
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after accept");
  assert property (@(posedge clk) disable iff (rst) accepted |-> done)
    else $error("accepted without done");
endmodule

>>> rtl/hdmc_ram.sv
// Generic single-port RAM with registered read.
module hdmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/hdmc_cell.sv
// One stage of the overlap-test chain: a stored disk flows through the cells.
module hdmc_cell #(
  parameter int CB = 16,
  parameter int KIND = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [CB-1:0]       in_a,
  input  logic [CB-1:0]       in_b,
  input  logic [2*CB+1:0]     in_c,
  input  logic [CB-1:0]       cand_x,
  input  logic [CB-1:0]       cand_y,
  output logic                out_vld,
  output logic [CB-1:0]       out_a,
  output logic [CB-1:0]       out_b,
  output logic [2*CB+1:0]     out_c
);
  // KIND 0: minimum-image gaps from (x,y); KIND 1: sum of squared gaps in c
  logic [CB-1:0]   ga, gb;
  logic [CB-1:0]   da, db;
  logic [CB-1:0]   ra, rb;
  logic [2*CB+1:0] rc;
  logic [2*CB-1:0] sqa, sqb;

  always_comb begin
    da = cand_x - in_a;
    db = cand_y - in_b;
    ga = da[CB-1] ? (~da + 1'b1) : da;
    gb = db[CB-1] ? (~db + 1'b1) : db;
    sqa = in_a * in_a;
    sqb = in_b * in_b;
    ra = in_a;
    rb = in_b;
    rc = in_c;
    case (KIND)
      0: begin
        ra = ga;
        rb = gb;
      end
      1: begin
        ra = '0;
        rb = '0;
        rc = {2'b00, sqa} + {2'b00, sqb};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_a <= ra;
    out_b <= rb;
    out_c <= rc;
  end
endmodule
